// ===== hdl/clrde_pkg.sv =====
// ---------------------------------------------------------------------------
// clrde_pkg: shared definitions of the character LCD refresh engine
// Widths, display command constants, codes and the cell command type.
// ---------------------------------------------------------------------------
`default_nettype none

package clrde_pkg;

  localparam int unsigned CELL_COUNT_DEF     = 32;
  localparam int unsigned CELLS_PER_LINE_DEF = 16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CURSOR_W = 5;

  localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
  localparam logic [CHAR_W-1:0] CMD_SET_ADDRESS = 8'h80;
  localparam logic [CHAR_W-1:0] LINE2_BASE      = 8'h40;
  localparam logic [CHAR_W-1:0] ADDRESS_MASK    = 8'h7F;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STEP_SCAN   = 2'd0,
    STEP_ADDR   = 2'd1,
    STEP_DATA   = 2'd2,
    STEP_CURSOR = 2'd3
  } step_e;

  typedef enum logic {
    CTRL_IDLE   = 1'b0,
    CTRL_SEARCH = 1'b1
  } ctrl_e;

  // Load request for one cell of the frame buffer.
  typedef struct packed {
    logic              load;
    logic [CHAR_W-1:0] data;
  } cell_cmd_t;

  // Set-DDRAM-address command for a cell of a two-line display.
  function automatic logic [CHAR_W-1:0] address_command(input logic [CHAR_W-1:0] cell_idx,
                                                        input logic [CHAR_W-1:0] per_line);
    logic [CHAR_W-1:0] addr;
    if (cell_idx < per_line) begin
      addr = cell_idx;
    end else begin
      addr = LINE2_BASE + (cell_idx - per_line);
    end
    return CMD_SET_ADDRESS | (addr & ADDRESS_MASK);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/clrde_in_if.sv =====
// ---------------------------------------------------------------------------
// clrde_in_if: input channel of the character LCD refresh engine
// Valid/ready channel carrying host writes, clears and refresh ticks.
// ---------------------------------------------------------------------------
`default_nettype none

interface clrde_in_if;
  logic                            valid;
  logic                            ready;
  logic [clrde_pkg::MODE_W-1:0]    mode;
  logic [clrde_pkg::INDEX_W-1:0]   cell_index;
  logic [clrde_pkg::CHAR_W-1:0]    char_code;
  logic                            display_busy;

  modport source (output valid, output mode, output cell_index, output char_code,
                  output display_busy, input ready);
  modport sink   (input valid, input mode, input cell_index, input char_code,
                  input display_busy, output ready);
endinterface

`default_nettype wire

// ===== hdl/clrde_out_if.sv =====
// ---------------------------------------------------------------------------
// clrde_out_if: output channel of the character LCD refresh engine
// Valid/ready channel carrying bytes for the display.
// ---------------------------------------------------------------------------
`default_nettype none

interface clrde_out_if;
  logic                          valid;
  logic                          ready;
  logic [clrde_pkg::CHAR_W-1:0]  lcd_byte;
  logic                          register_select;

  modport source (output valid, output lcd_byte, output register_select, input ready);
  modport sink   (input valid, input lcd_byte, input register_select, output ready);
endinterface

`default_nettype wire

// ===== hdl/clrde_cell.sv =====
// ---------------------------------------------------------------------------
// clrde_cell: one character cell of the refresh chain
// Holds the buffer byte and the shown byte of one cell and passes the
// search token to its neighbor when the cell is clean.
// ---------------------------------------------------------------------------
`default_nettype none

module clrde_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clrde_pkg::cell_cmd_t          cmd_i,
  input  logic                          token_i,
  output logic                          token_o,
  output logic                          hit_o,
  output logic [clrde_pkg::CHAR_W-1:0]  char_o
);
  import clrde_pkg::*;

  logic [CHAR_W-1:0] frame_q, frame_d;
  logic [CHAR_W-1:0] shadow_q, shadow_d;
  logic              token_q;
  logic              dirty;

  assign dirty   = (frame_q != shadow_q);
  assign hit_o   = token_q & dirty;
  assign token_o = token_q & ~dirty;
  assign char_o  = hit_o ? frame_q : '0;

  always_comb begin
    frame_d  = cmd_i.load ? cmd_i.data : frame_q;
    shadow_d = hit_o ? frame_q : shadow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      shadow_q <= '0;
      token_q  <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      shadow_q <= shadow_d;
      token_q  <= token_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/char_lcd_dirty_refresh_engine.sv =====
// ---------------------------------------------------------------------------
// char_lcd_dirty_refresh_engine: dirty-cell refresh for a two-line LCD
// Keeps a frame buffer and a shadow copy in a chain of cells, finds the
// lowest changed cell and sends address, character and cursor commands.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                      Handshake
//  in_i      in         mode, cell_index, char_code, display_busy    valid/ready
//  out_o     out        lcd_byte, register_select                    valid/ready
//  cursor_*  in         cursor_wdata_i (5 bits)                      write enable
//
//  Writes and clears load the cells directly; a tick outside the scan step
//  advances the refresh step unless display_busy is set. A tick in the scan
//  step starts a search token that walks the cell chain one cell per cycle;
//  no input transaction is taken during the walk. Reset clears every cell at once.
//  The input is held off while a result waits and the output is stalled.
`default_nettype none

module char_lcd_dirty_refresh_engine #(
  parameter int unsigned CELL_COUNT     = clrde_pkg::CELL_COUNT_DEF,
  parameter int unsigned CELLS_PER_LINE = clrde_pkg::CELLS_PER_LINE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cursor_we_i,
  input  logic [clrde_pkg::CURSOR_W-1:0]  cursor_wdata_i,
  clrde_in_if.sink                        in_i,
  clrde_out_if.source                     out_o
);
  import clrde_pkg::*;

  localparam int unsigned IDX_W = $clog2(CELL_COUNT);

  logic [CURSOR_W-1:0] cursor_q;
  ctrl_e               ctrl_q, ctrl_d;
  step_e               step_q, step_d;
  logic [IDX_W-1:0]    pending_q, pending_d;
  logic [CHAR_W-1:0]   pending_char_q, pending_char_d;
  logic [IDX_W-1:0]    scan_idx_q, scan_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_byte_q, out_byte_d;
  logic                out_rs_q, out_rs_d;

  cell_cmd_t           cmd [CELL_COUNT];
  logic [CELL_COUNT:0] token;
  logic [CELL_COUNT-1:0] hit;
  logic [CHAR_W-1:0]   cell_char [CELL_COUNT];
  logic [CHAR_W-1:0]   hit_char;
  logic                hit_any;
  logic                search_done;
  logic                in_accept;
  logic                is_write;
  logic                is_clear;
  logic                is_tick;
  logic                start_search;

  assign in_i.ready = (ctrl_q == CTRL_IDLE) && (!out_valid_q || out_o.ready);
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    is_write = 1'b0;
    is_clear = 1'b0;
    is_tick  = 1'b0;
    case (mode_e'(in_i.mode))
      MODE_WRITE: is_write = in_accept;
      MODE_CLEAR: is_clear = in_accept;
      MODE_TICK:  is_tick  = in_accept;
      default: ;
    endcase
  end

  assign start_search = is_tick && (step_q == STEP_SCAN);
  assign token[0]     = start_search;

  // Row of cells; the token enters at the lowest cell.
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    always_comb begin
      cmd[i].load = is_clear ||
                    (is_write && (8'(in_i.cell_index) == 8'(i)));
      cmd[i].data = is_clear ? SPACE_CODE : in_i.char_code;
    end

    clrde_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[i]),
      .token_i (token[i]),
      .token_o (token[i+1]),
      .hit_o   (hit[i]),
      .char_o  (cell_char[i])
    );
  end

  always_comb begin
    hit_char = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      hit_char = hit_char | cell_char[i];
    end
  end

  assign hit_any     = |hit;
  assign search_done = hit_any || token[CELL_COUNT];

  // Next-state logic of the controller.
  always_comb begin
    ctrl_d = ctrl_q;
    case (ctrl_q)
      CTRL_IDLE:   if (start_search) ctrl_d = CTRL_SEARCH;
      CTRL_SEARCH: if (search_done) ctrl_d = CTRL_IDLE;
      default:     ctrl_d = CTRL_IDLE;
    endcase
  end

  // Refresh step, pending cell and result register.
  always_comb begin
    step_d         = step_q;
    pending_d      = pending_q;
    pending_char_d = pending_char_q;
    scan_idx_d     = scan_idx_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_byte_d     = out_byte_q;
    out_rs_d       = out_rs_q;

    case (ctrl_q)
      CTRL_IDLE: begin
        if (start_search) begin
          scan_idx_d = '0;
        end else if (is_tick && !in_i.display_busy) begin
          case (step_q)
            STEP_ADDR: begin
              step_d      = STEP_DATA;
              out_valid_d = 1'b1;
              out_byte_d  = address_command(8'(pending_q), 8'(CELLS_PER_LINE));
              out_rs_d    = 1'b0;
            end
            STEP_DATA: begin
              step_d      = STEP_CURSOR;
              out_valid_d = 1'b1;
              out_byte_d  = pending_char_q;
              out_rs_d    = 1'b1;
            end
            STEP_CURSOR: begin
              step_d = STEP_SCAN;
              if (8'(cursor_q) < 8'(CELL_COUNT)) begin
                out_valid_d = 1'b1;
                out_byte_d  = address_command(8'(cursor_q), 8'(CELLS_PER_LINE));
                out_rs_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      CTRL_SEARCH: begin
        scan_idx_d = IDX_W'(scan_idx_q + 1'b1);
        if (hit_any) begin
          pending_d      = scan_idx_q;
          pending_char_d = hit_char;
          step_d         = STEP_ADDR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      ctrl_q      <= CTRL_IDLE;
      step_q      <= STEP_SCAN;
      pending_q   <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cursor_we_i) begin
        cursor_q <= cursor_wdata_i;
      end
      ctrl_q      <= ctrl_d;
      step_q      <= step_d;
      pending_q   <= pending_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pending_char_q <= pending_char_d;
    out_byte_q     <= out_byte_d;
    out_rs_q       <= out_rs_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.lcd_byte        = out_byte_q;
  assign out_o.register_select = out_rs_q;

endmodule

`default_nettype wire
